FILE: sv/assert_macros.svh
// Assertion helpers for the rsm blocks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RSM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("rsm check failed");
`define RSM_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("rsm never");
`else
`define RSM_ASSERT(lbl, clk, rst_n, prop)
`define RSM_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: sv/rsm_pkg.sv
`default_nettype none
package rsm_pkg;
  localparam int NUM_SLOTS   = 7;
  localparam int FRAME_BYTES = 512;
  localparam int NUM_REGS    = 32;   // power of two: index wraps by truncation
  localparam int REG_AW      = $clog2(NUM_REGS);
  localparam int CFG_W       = 7;
  localparam int ROW_COUNT   = FRAME_BYTES / 8;
  localparam int ROW_AW      = $clog2(ROW_COUNT);
  localparam int FRAME_AW    = $clog2(FRAME_BYTES);
  localparam int ADDR_W      = $clog2(NUM_SLOTS * (2**CFG_W - 1) + FRAME_BYTES + 9);

  typedef enum logic [4:0] {
    K_MOV = 5'd0, K_SETIMM = 5'd1, K_GT = 5'd2, K_LT = 5'd3, K_GE = 5'd4,
    K_LE = 5'd5, K_EQ = 5'd6, K_NE = 5'd7, K_RET = 5'd8, K_ADD = 5'd9,
    K_SUB = 5'd10, K_MUL = 5'd11, K_DIV = 5'd12, K_MOD = 5'd13,
    K_ST = 5'd14, K_STREG = 5'd15, K_LD = 5'd16
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_DIVZ = 2'd1, ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_EXEC = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_DIV  = 8'b0000_1000,
    S_LDA  = 8'b0001_0000,
    S_LDB  = 8'b0010_0000,
    S_STB  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic              en;
    logic [ROW_AW-1:0] row;
    logic [63:0]       data;
    logic [7:0]        mask;
  } frm_wr_t;
endpackage
`default_nettype wire

FILE: sv/rsm_regfile.sv
`default_nettype none
module rsm_regfile
  import rsm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rd_en_i,
  input  wire logic [REG_AW-1:0] rd_a_addr_i,
  input  wire logic [REG_AW-1:0] rd_b_addr_i,
  output logic [63:0]            rd_a_data_o,
  output logic [63:0]            rd_b_data_o,
  input  wire logic              wr_en_i,
  input  wire logic [REG_AW-1:0] wr_addr_i,
  input  wire logic [63:0]       wr_data_i
);
  logic [63:0]         mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_q;
  logic [63:0]         a_q, b_q;
  logic                av_q, bv_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      a_q <= mem[rd_a_addr_i];
      b_q <= mem[rd_b_addr_i];
    end
  end

  // unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      av_q  <= 1'b0;
      bv_q  <= 1'b0;
    end else begin
      if (wr_en_i) vld_q[wr_addr_i] <= 1'b1;
      if (rd_en_i) begin
        av_q <= vld_q[rd_a_addr_i];
        bv_q <= vld_q[rd_b_addr_i];
      end
    end
  end

  assign rd_a_data_o = av_q ? a_q : 64'd0;
  assign rd_b_data_o = bv_q ? b_q : 64'd0;
endmodule
`default_nettype wire

FILE: sv/rsm_frame.sv
`default_nettype none
module rsm_frame
  import rsm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rd_en_i,
  input  wire logic [ROW_AW-1:0] rd_row_i,
  output logic [63:0]            rd_data_o,
  input  wire frm_wr_t           wr_i
);
  logic [63:0]          mem [ROW_COUNT];
  logic [ROW_COUNT-1:0] vld_q;
  logic [63:0]          rd_q;
  logic                 rv_q;

  // a first write to a row zero-fills the bytes it does not cover
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      for (int k = 0; k < 8; k++) begin
        if (wr_i.mask[k] || !vld_q[wr_i.row]) begin
          mem[wr_i.row][8*k +: 8] <= wr_i.mask[k] ? wr_i.data[8*k +: 8] : 8'h00;
        end
      end
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_row_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rv_q  <= 1'b0;
    end else begin
      if (wr_i.en) vld_q[wr_i.row] <= 1'b1;
      if (rd_en_i) rv_q <= vld_q[rd_row_i];
    end
  end

  assign rd_data_o = rv_q ? rd_q : 64'd0;
endmodule
`default_nettype wire

FILE: sv/rsm_div.sv
`default_nettype none
module rsm_div
  import rsm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [63:0] divisor_i,
  output logic             done_o,
  output logic [63:0]      quo_o,
  output logic [63:0]      rem_o
);
  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [63:0] quo_q, rem_q, den_q;
  logic [64:0] trial;
  logic        fits;

  // restoring, one quotient bit per cycle
  assign trial = {rem_q, quo_q[63]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[62:0], fits};
      rem_q <= fits ? 64'(trial - {1'b0, den_q}) : trial[63:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

FILE: sv/register_stack_machine_execute.sv
// Register stack machine execute unit.
// Input channel (in_valid_i / in_ready_o): one instruction per request; the
// fields are sampled at the accepting edge. Output channel (out_valid_o /
// out_ready_i): one result per instruction (status, value, returned flag).
// Config port: cfg_we_i writes slot size cfg_idx_i; index 7 is ignored.
// Only write it while no instruction is in flight.
// From accept to result valid: moves, compares, add/sub, return, invalid
// kinds and stores go from execute straight to done (a store that crosses
// an 8-byte row also writes the next row); loads read two rows; mul
// makes three passes through one 32x32 multiplier; div/mod run the radix-2
// divider, 64 iterations. Zero divisor or out-of-frame access skips to done.
// One instruction is in flight at a time; the next request is taken as soon
// as the result sits in the output register, so a stalled receiver only
// blocks once a second result is ready to go out.
// Reset: registers, frame and slot sizes read as zero; valid bits per
// register and per frame row stand in for a clearing pass, so no clearing
// pass has to run after reset.
`default_nettype none
module register_stack_machine_execute
  import rsm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [CFG_W-1:0]   cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [4:0]         kind_i,
  input  wire logic               indexed_access_i,
  input  wire logic [4:0]         dest_reg_i,
  input  wire logic [4:0]         src_a_reg_i,
  input  wire logic [4:0]         src_b_reg_i,
  input  wire logic signed [63:0] immediate_i,
  input  wire logic [2:0]         slot_index_i,
  input  wire logic               access_32_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              status_o,
  output logic signed [63:0]      value_o,
  output logic                    returned_o
);
`include "assert_macros.svh"

  state_e state_q, state_d;

  // slot sizes
  logic [CFG_W-1:0] slot_sz_q [NUM_SLOTS];

  // latched request
  kind_e             kind_q;
  logic              idx_q, a32_q;
  logic [REG_AW-1:0] dest_q;
  logic [63:0]       imm_q;
  logic [2:0]        slot_q;

  // pending result
  logic [63:0] res_val_q;
  status_e     res_st_q;
  logic        res_ret_q, res_wr_q;

  // output register
  logic        out_vld_q, out_ret_q;
  logic [63:0] out_val_q;
  status_e     out_st_q;

  // operands
  logic [63:0] op_a, op_b;
  logic        accept, emit;

  rsm_regfile u_rf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_a_addr_i (src_a_reg_i[REG_AW-1:0]),
    .rd_b_addr_i (src_b_reg_i[REG_AW-1:0]),
    .rd_a_data_o (op_a),
    .rd_b_data_o (op_b),
    .wr_en_i     (emit && res_wr_q),
    .wr_addr_i   (dest_q),
    .wr_data_i   (res_val_q)
  );

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign emit = (state_q == S_DONE) && (!out_vld_q || out_ready_i);

  // ---------------- frame address ----------------
  logic [ADDR_W-1:0] base, start;
  logic              dyn_en, dyn_big, in_range;
  logic [3:0]        width;

  always_comb begin
    base = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (3'(i) < slot_q) base = base + ADDR_W'(slot_sz_q[i]);
    end
  end

  assign dyn_en  = (kind_q == K_STREG) || (kind_q == K_LD && idx_q);
  assign dyn_big = op_b > 64'(FRAME_BYTES);
  assign width   = a32_q ? 4'd4 : 4'd8;
  assign start   = base + (dyn_en ? ADDR_W'(op_b[FRAME_AW:0]) : '0);
  assign in_range = !(dyn_en && dyn_big) &&
                    (ADDR_W'(start + ADDR_W'(width)) <= ADDR_W'(FRAME_BYTES));

  logic [ROW_AW-1:0] row_q;
  logic [2:0]        off_q;
  logic [63:0]       lo_q;

  // store data/mask spread over two rows
  logic [127:0] st_data;
  logic [15:0]  st_mask;
  logic [2:0]   cur_off;
  assign cur_off = (state_q == S_EXEC) ? start[2:0] : off_q;
  assign st_data = {64'd0, op_a} << {cur_off, 3'b000};
  assign st_mask = {8'd0, (a32_q ? 8'h0F : 8'hFF)} << cur_off;

  frm_wr_t     frm_wr;
  logic        frm_rd_en;
  logic [ROW_AW-1:0] frm_rd_row;
  logic [63:0] frm_rd_data;

  always_comb begin
    frm_wr     = '0;
    frm_rd_en  = 1'b0;
    frm_rd_row = start[FRAME_AW-1:3];
    if (state_q == S_EXEC && in_range) begin
      if (kind_q == K_ST || kind_q == K_STREG) begin
        frm_wr.en   = 1'b1;
        frm_wr.row  = start[FRAME_AW-1:3];
        frm_wr.data = st_data[63:0];
        frm_wr.mask = st_mask[7:0];
      end else if (kind_q == K_LD) begin
        frm_rd_en = 1'b1;
      end
    end
    if (state_q == S_LDA) begin
      frm_rd_en  = 1'b1;
      frm_rd_row = row_q + ROW_AW'(1);
    end
    if (state_q == S_STB) begin
      frm_wr.en   = 1'b1;
      frm_wr.row  = row_q + ROW_AW'(1);
      frm_wr.data = st_data[127:64];
      frm_wr.mask = st_mask[15:8];
    end
  end

  rsm_frame u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (frm_rd_en),
    .rd_row_i  (frm_rd_row),
    .rd_data_o (frm_rd_data),
    .wr_i      (frm_wr)
  );

  // load assembly
  logic [127:0] ld_cat;
  logic [63:0]  ld_raw, ld_val;
  assign ld_cat = {frm_rd_data, lo_q} >> {off_q, 3'b000};
  assign ld_raw = ld_cat[63:0];
  assign ld_val = a32_q ? {{32{ld_raw[31]}}, ld_raw[31:0]} : ld_raw;

  // ---------------- multiply: three 32x32 passes ----------------
  logic [1:0]  mul_cnt_q;
  logic [63:0] mul_acc_q, mul_acc_d, mul_p;
  logic [31:0] mul_x, mul_y;

  always_comb begin
    mul_x = (mul_cnt_q == 2'd2) ? op_a[63:32] : op_a[31:0];
    mul_y = (mul_cnt_q == 2'd1) ? op_b[63:32] : op_b[31:0];
    mul_p = mul_x * mul_y;
    mul_acc_d = (mul_cnt_q == 2'd0) ? mul_p : mul_acc_q + {mul_p[31:0], 32'd0};
  end

  // ---------------- divide ----------------
  logic        a_neg, b_neg, div_start, div_done;
  logic [63:0] div_q, div_r;
  assign a_neg = op_a[63];
  assign b_neg = op_b[63];
  assign div_start = (state_q == S_EXEC) && (kind_q == K_DIV || kind_q == K_MOD) &&
                     (op_b != 64'd0);

  rsm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (a_neg ? 64'd0 - op_a : op_a),
    .divisor_i  (b_neg ? 64'd0 - op_b : op_b),
    .done_o     (div_done),
    .quo_o      (div_q),
    .rem_o      (div_r)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_EXEC;
      S_EXEC: begin
        state_d = S_DONE;
        case (kind_q)
          K_MUL: state_d = S_MUL;
          K_DIV, K_MOD: if (op_b != 64'd0) state_d = S_DIV;
          K_LD: if (in_range) state_d = S_LDA;
          K_ST, K_STREG: if (in_range && st_mask[15:8] != 8'd0) state_d = S_STB;
          default: state_d = S_DONE;
        endcase
      end
      S_MUL:  if (mul_cnt_q == 2'd2) state_d = S_DONE;
      S_DIV:  if (div_done) state_d = S_DONE;
      S_LDA:  state_d = S_LDB;
      S_LDB:  state_d = S_DONE;
      S_STB:  state_d = S_DONE;
      S_DONE: if (emit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      mul_cnt_q <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) slot_sz_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && cfg_idx_i < 3'(NUM_SLOTS)) begin
        slot_sz_q[cfg_idx_i] <= cfg_wdata_i;
      end
      if (emit) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
      if (state_q == S_MUL) mul_cnt_q <= mul_cnt_q + 2'd1;
      else mul_cnt_q <= '0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_e'(kind_i);
      idx_q  <= indexed_access_i;
      dest_q <= dest_reg_i[REG_AW-1:0];
      imm_q  <= immediate_i;
      slot_q <= slot_index_i;
      a32_q  <= access_32_i;
    end
    if (state_q == S_MUL) mul_acc_q <= mul_acc_d;
    if (state_q == S_LDA) lo_q <= frm_rd_data;
    if (emit) begin
      out_val_q <= res_val_q;
      out_st_q  <= res_st_q;
      out_ret_q <= res_ret_q;
    end
    case (state_q)
      S_EXEC: begin
        res_val_q <= '0;
        res_st_q  <= ST_OK;
        res_ret_q <= 1'b0;
        res_wr_q  <= 1'b0;
        row_q     <= start[FRAME_AW-1:3];
        off_q     <= start[2:0];
        case (kind_q)
          K_MOV:    begin res_val_q <= op_a;  res_wr_q <= 1'b1; end
          K_SETIMM: begin res_val_q <= imm_q; res_wr_q <= 1'b1; end
          K_GT: begin res_val_q <= 64'($signed(op_b) < $signed(op_a));  res_wr_q <= 1'b1; end
          K_LT: begin res_val_q <= 64'($signed(op_a) < $signed(op_b));  res_wr_q <= 1'b1; end
          K_GE: begin res_val_q <= 64'($signed(op_a) >= $signed(op_b)); res_wr_q <= 1'b1; end
          K_LE: begin res_val_q <= 64'($signed(op_b) >= $signed(op_a)); res_wr_q <= 1'b1; end
          K_EQ: begin res_val_q <= 64'(op_a == op_b); res_wr_q <= 1'b1; end
          K_NE: begin res_val_q <= 64'(op_a != op_b); res_wr_q <= 1'b1; end
          K_RET: begin res_val_q <= op_a; res_ret_q <= 1'b1; end
          K_ADD: begin res_val_q <= op_a + op_b; res_wr_q <= 1'b1; end
          K_SUB: begin res_val_q <= op_a - op_b; res_wr_q <= 1'b1; end
          K_DIV, K_MOD: if (op_b == 64'd0) res_st_q <= ST_DIVZ;
          K_ST, K_STREG: begin
            if (!in_range) res_st_q <= ST_RANGE;
            else res_val_q <= a32_q ? {{32{op_a[31]}}, op_a[31:0]} : op_a;
          end
          K_LD: if (!in_range) res_st_q <= ST_RANGE;
          default: res_val_q <= '0;
        endcase
      end
      S_MUL: if (mul_cnt_q == 2'd2) begin
        res_val_q <= mul_acc_d;
        res_wr_q  <= 1'b1;
      end
      S_DIV: if (div_done) begin
        res_wr_q <= 1'b1;
        if (kind_q == K_DIV) res_val_q <= (a_neg != b_neg) ? 64'd0 - div_q : div_q;
        else res_val_q <= a_neg ? 64'd0 - div_r : div_r;
      end
      S_LDB: begin
        res_val_q <= ld_val;
        res_wr_q  <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_vld_q;
  assign status_o    = out_st_q;
  assign value_o     = out_val_q;
  assign returned_o  = out_ret_q;

  `RSM_ASSERT(a_accept_exec, clk_i, rst_ni, accept |=> (state_q == S_EXEC))
  `RSM_ASSERT(a_err_zero, clk_i, rst_ni, (out_vld_q && out_st_q != ST_OK) |-> (out_val_q == 64'd0))
  `RSM_ASSERT(a_ret_ok, clk_i, rst_ni, (out_vld_q && out_ret_q) |-> (out_st_q == ST_OK))
  `RSM_NEVER(a_div_done_state, clk_i, rst_ni, div_done && state_q != S_DIV)
endmodule
`default_nettype wire
